>>> sv/smaa_pkg.sv
// Shared constants and types for the sensor moving-average alarm core.
// No dependencies; every other file imports this package.
package smaa_pkg;

    localparam int CHANNELS    = 8;
    localparam int WINDOW_DEF  = 8;
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int ID_W        = 16;
    localparam int TEMP_W      = 16;
    localparam int ROOM_W      = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 16'sd2560;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd7680;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b1;

    localparam logic [ID_W-1:0] CHAN_IDS [CHANNELS] = '{
        16'd15, 16'd21, 16'd37, 16'd49, 16'd112, 16'd129, 16'd132, 16'd142
    };
    localparam logic [ROOM_W-1:0] CHAN_ROOMS [CHANNELS] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd11, 4'd12, 4'd13, 4'd14
    };

    // per-item control that travels down the pipeline
    typedef struct packed {
        logic            known;
        logic [CH_W-1:0] ch;
        logic            full;
    } t_tag;

endpackage

>>> sv/smaa_window.sv
// Id match, per-channel slot/fill tracking and window memory (first stage).
// Depends on smaa_pkg.
module smaa_window import smaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [ID_W-1:0]          i_sensor_id,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output t_tag                     o_tag,
    output logic signed [TEMP_W-1:0] o_temp,
    output logic signed [TEMP_W-1:0] o_old
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    logic [SLOT_W-1:0]        r_slot [CHANNELS];
    logic [FILL_W-1:0]        r_fill [CHANNELS];
    logic signed [TEMP_W-1:0] mem    [CHANNELS][WINDOW];

    logic signed [TEMP_W-1:0] r_old_raw;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_was_full;
    t_tag                     r_tag;

    logic              hit;
    logic [CH_W-1:0]   ch;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] n_slot;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] n_fill;
    logic              was_full;

    always_comb begin
        hit = 1'b0;
        ch  = '0;
        // descending scan so the lowest matching channel wins
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (i_sensor_id == CHAN_IDS[c]) begin
                hit = 1'b1;
                ch  = CH_W'(c);
            end
        end
        slot     = r_slot[ch];
        fill     = r_fill[ch];
        was_full = (fill == FILL_W'(WINDOW));
        n_fill   = was_full ? fill : fill + FILL_W'(1);
        n_slot   = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_slot[c] <= '0;
                r_fill[c] <= '0;
            end
        end else if (i_en && hit) begin
            r_slot[ch] <= n_slot;
            r_fill[ch] <= n_fill;
        end
    end

    // read-before-write: the old entry leaves as the new reading lands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_old_raw  <= mem[ch][slot];
            r_temp     <= i_temperature;
            r_was_full <= was_full;
            r_tag      <= '{known: hit, ch: ch, full: (n_fill == FILL_W'(WINDOW))};
            if (hit) begin
                mem[ch][slot] <= i_temperature;
            end
        end
    end

    // until the window is full the slot being replaced was never written
    assign o_old  = r_was_full ? r_old_raw : '0;
    assign o_temp = r_temp;
    assign o_tag  = r_tag;

endmodule

>>> sv/smaa_sum.sv
// Per-channel running sum update (second stage).
// Depends on smaa_pkg.
module smaa_sum import smaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_tag                     i_tag,
    input  logic signed [TEMP_W-1:0] i_temp,
    input  logic signed [TEMP_W-1:0] i_old,
    output t_tag                     o_tag,
    output logic signed [TEMP_W+$clog2(WINDOW)-1:0] o_sum
);

    localparam int SUM_W = TEMP_W + $clog2(WINDOW);

    logic signed [SUM_W-1:0] r_sum [CHANNELS];
    logic signed [SUM_W-1:0] r_sum_out;
    t_tag                    r_tag;
    logic signed [SUM_W-1:0] n_sum;

    assign n_sum = r_sum[i_tag.ch] - SUM_W'(i_old) + SUM_W'(i_temp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_en && i_tag.known) begin
            r_sum[i_tag.ch] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_out <= n_sum;
            r_tag     <= i_tag;
        end
    end

    assign o_sum = r_sum_out;
    assign o_tag = r_tag;

endmodule

>>> sv/smaa_alarm.sv
// Floor average by reciprocal multiply, threshold compare and result register.
// Depends on smaa_pkg.
module smaa_alarm import smaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en_mul,
    input  logic                     i_en_out,
    input  t_tag                     i_tag,
    input  logic signed [TEMP_W+$clog2(WINDOW)-1:0] i_sum,
    input  logic signed [TEMP_W-1:0] i_min_temp,
    input  logic signed [TEMP_W-1:0] i_max_temp,
    output logic                     o_known,
    output logic [ROOM_W-1:0]        o_room_id,
    output logic signed [TEMP_W-1:0] o_average,
    output logic                     o_window_full,
    output logic                     o_too_cold,
    output logic                     o_too_hot
);

    localparam int SUM_W = TEMP_W + $clog2(WINDOW);
    localparam int SHIFT = SUM_W + $clog2(WINDOW);
    localparam int MUL_W = SHIFT + 1;
    // ceil(2^SHIFT / WINDOW): exact quotient for every biased sum
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    // bias of 2^15 * WINDOW makes the sum non-negative; quotient bias is 2^15
    localparam logic [SUM_W-1:0] BIAS = SUM_W'(64'(WINDOW) << (TEMP_W - 1));

    logic [SUM_W-1:0]       biased;
    logic [SUM_W+MUL_W-1:0] prod;
    logic [TEMP_W-1:0]      r_q;
    t_tag                   r_tag;

    logic signed [TEMP_W-1:0] avg;

    logic                     r_known;
    logic [ROOM_W-1:0]        r_room_id;
    logic signed [TEMP_W-1:0] r_average;
    logic                     r_window_full;
    logic                     r_too_cold;
    logic                     r_too_hot;

    assign biased = SUM_W'(unsigned'(i_sum)) + BIAS;
    assign prod   = (SUM_W+MUL_W)'(biased) * (SUM_W+MUL_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_q   <= prod[SHIFT +: TEMP_W];
            r_tag <= i_tag;
        end
    end

    // remove the quotient bias by flipping the top bit
    assign avg = signed'({~r_q[TEMP_W-1], r_q[TEMP_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_known       <= r_tag.known;
            r_room_id     <= r_tag.known ? CHAN_ROOMS[r_tag.ch] : '0;
            r_average     <= r_tag.known ? avg : '0;
            r_window_full <= r_tag.known && r_tag.full;
            r_too_cold    <= r_tag.known && r_tag.full && (avg < i_min_temp);
            r_too_hot     <= r_tag.known && r_tag.full && (avg > i_max_temp);
        end
    end

    assign o_known       = r_known;
    assign o_room_id     = r_room_id;
    assign o_average     = r_average;
    assign o_window_full = r_window_full;
    assign o_too_cold    = r_too_cold;
    assign o_too_hot     = r_too_hot;

endmodule

>>> sv/sensor_moving_average_alarm_core.sv
// Top level: stream handshake, threshold registers and the four-stage pipeline.
// Depends on smaa_pkg, smaa_window, smaa_sum, smaa_alarm.
//
//  port group  dir  contents
//  s_axis      in   tdata = sensor_id[15:0], temperature[31:16]
//  m_axis      out  tuser = known; tdata = room_id[3:0], average[19:4],
//                   window_full[20], too_cold[21], too_hot[22], zero[23]
//  i_cfg       in   we / index / data: 0 = min_temp, 1 = max_temp
//
//  One item per cycle while m_axis_tready does not hold the output back.
//  Stages: window memory read/write, running sum, reciprocal multiply, compare.
//  Each stage holds only while the one after it is full and held, so bubbles
//  close up and input is still taken while a result waits on m_axis_tready.
//  Synchronous active-low reset clears channel state and reloads the default thresholds.
module sensor_moving_average_alarm_core import smaa_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TEMP_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // sensor_id, temperature
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // room_id, average, window_full,
                                                 // too_cold, too_hot, pad
    output logic [0:0]           m_axis_tuser    // known
);

    localparam int SUM_W = TEMP_W + $clog2(WINDOW);

    logic signed [TEMP_W-1:0] r_min_temp;
    logic signed [TEMP_W-1:0] r_max_temp;
    logic r_v1, r_v2, r_v3, r_v4;
    logic en2, en3, en4, accept;

    t_tag                     tag1, tag2;
    logic signed [TEMP_W-1:0] temp1, old1;
    logic signed [SUM_W-1:0]  sum2;

    logic                     known;
    logic [ROOM_W-1:0]        room_id;
    logic signed [TEMP_W-1:0] average;
    logic                     window_full, too_cold, too_hot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= MIN_TEMP_RST;
            r_max_temp <= MAX_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_TEMP: r_min_temp <= signed'(i_cfg_data);
                CFG_MAX_TEMP: r_max_temp <= signed'(i_cfg_data);
            endcase
        end
    end

    assign en4           = !r_v4 || m_axis_tready;
    assign en3           = !r_v3 || en4;
    assign en2           = !r_v2 || en3;
    assign s_axis_tready = !r_v1 || en2;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s_axis_tready) r_v1 <= s_axis_tvalid;
            if (en2)           r_v2 <= r_v1;
            if (en3)           r_v3 <= r_v2;
            if (en4)           r_v4 <= r_v3;
        end
    end

    smaa_window #(.WINDOW(WINDOW)) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (accept),
        .i_sensor_id   (s_axis_tdata[15:0]),
        .i_temperature (signed'(s_axis_tdata[31:16])),
        .o_tag         (tag1),
        .o_temp        (temp1),
        .o_old         (old1)
    );

    smaa_sum #(.WINDOW(WINDOW)) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2 && r_v1),
        .i_tag   (tag1),
        .i_temp  (temp1),
        .i_old   (old1),
        .o_tag   (tag2),
        .o_sum   (sum2)
    );

    smaa_alarm #(.WINDOW(WINDOW)) u_alarm (
        .i_clk         (i_clk),
        .i_en_mul      (en3),
        .i_en_out      (en4),
        .i_tag         (tag2),
        .i_sum         (sum2),
        .i_min_temp    (r_min_temp),
        .i_max_temp    (r_max_temp),
        .o_known       (known),
        .o_room_id     (room_id),
        .o_average     (average),
        .o_window_full (window_full),
        .o_too_cold    (too_cold),
        .o_too_hot     (too_hot)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = known;
    assign m_axis_tdata  = {1'b0, too_hot, too_cold, window_full,
                            unsigned'(average), room_id};

endmodule

>>> sv/smaa_checker.sv
// Port-level checks for the alarm core, bound to the top level.
// Depends on smaa_pkg and sensor_moving_average_alarm_core.
module smaa_checker import smaa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [23:0]          m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    // an unknown sensor reports an all-zero result
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
        else $error("unknown id with nonzero result");

    // alarms only on a full window
    a_alarm_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[21] || m_axis_tdata[22]) |-> m_axis_tdata[20])
        else $error("alarm raised before window full");

    // every known sensor maps to a nonzero room
    a_room_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[3:0] != 4'd0)))
        else $error("room id disagrees with known flag");

    // no result without an earlier accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
        else $error("result without matching input");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

endmodule

bind sensor_moving_average_alarm_core smaa_checker u_smaa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sensor_moving_average_alarm_core: per-channel window
// average and cold/hot alarms checked against a behavioral predictor in this file.
// Depends on smaa_pkg and the core RTL.
module tb;
    import smaa_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 125;

    localparam logic [ID_W-1:0] SENSOR_IDS [CHANNELS] = '{
        16'd15, 16'd21, 16'd37, 16'd49, 16'd112, 16'd129, 16'd132, 16'd142
    };
    localparam logic [ROOM_W-1:0] SENSOR_ROOMS [CHANNELS] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd11, 4'd12, 4'd13, 4'd14
    };

    typedef struct {
        logic [ID_W-1:0]          sensor_id;
        logic signed [TEMP_W-1:0] temperature;
    } t_reading;

    typedef struct {
        logic                     known;
        logic [ROOM_W-1:0]        room;
        logic signed [TEMP_W-1:0] average;
        logic                     full;
        logic                     cold;
        logic                     hot;
    } t_report;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [TEMP_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    sensor_moving_average_alarm_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sensor_id, temperature
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // room_id, average, window_full, too_cold,
                                         // too_hot, pad
        .m_axis_tuser  (m_axis_tuser)    // known
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic signed [TEMP_W-1:0] win_vals [CHANNELS][WIN];
    int                       win_sum  [CHANNELS];
    int                       win_slot [CHANNELS];
    int                       win_fill [CHANNELS];
    logic signed [TEMP_W-1:0] thr_min = MIN_TEMP_RST;
    logic signed [TEMP_W-1:0] thr_max = MAX_TEMP_RST;

    t_reading pending_readings [$];
    t_report  expected_reports [$];
    t_reading offered;

    int   src_wait     = 0;
    int   sink_wait    = 0;
    int   n_accepted   = 0;
    int   quiet_cycles = 0;
    int   error_count  = 0;
    bit   src_idle_on  = 1'b0;
    bit   sink_idle_on = 1'b0;
    logic hold_on      = 1'b0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int draw_gap(input bit enable);
        return enable ? int'($urandom_range(0, 8)) : 0;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic t_report predict_report(input t_reading rd);
        t_report r;
        int      ch;
        int      slot;
        int      avg;
        r = '{default: '0};
        ch = -1;
        for (int c = 0; c < CHANNELS; c++)
            if (ch < 0 && rd.sensor_id == SENSOR_IDS[c])
                ch = c;
        if (ch < 0)
            return r;
        slot = win_slot[ch];
        win_sum[ch] = win_sum[ch] - int'(win_vals[ch][slot]) + int'(rd.temperature);
        win_vals[ch][slot] = rd.temperature;
        win_slot[ch] = (slot + 1 >= WIN) ? 0 : slot + 1;
        if (win_fill[ch] < WIN)
            win_fill[ch]++;
        // floor division, C-style / truncates toward zero
        avg = win_sum[ch] / WIN;
        if ((win_sum[ch] % WIN) != 0 && win_sum[ch] < 0)
            avg = avg - 1;
        r.known   = 1'b1;
        r.room    = SENSOR_ROOMS[ch];
        r.average = 16'(avg);
        r.full    = (win_fill[ch] >= WIN);
        r.cold    = r.full && (avg < int'(thr_min));
        r.hot     = r.full && (avg > int'(thr_max));
        return r;
    endfunction

    task automatic check_report();
        t_report want;
        if (expected_reports.size() == 0) begin
            flag_error($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
            return;
        end
        want = expected_reports.pop_front();
        if (m_axis_tuser[0] !== want.known)
            flag_error($sformatf("known got %b want %b", m_axis_tuser[0], want.known));
        if (m_axis_tdata[3:0] !== want.room)
            flag_error($sformatf("room got %0d want %0d", m_axis_tdata[3:0], want.room));
        if (m_axis_tdata[19:4] !== want.average)
            flag_error($sformatf("average got %0d want %0d",
                                 $signed(m_axis_tdata[19:4]), want.average));
        if (m_axis_tdata[20] !== want.full)
            flag_error($sformatf("window_full got %b want %b", m_axis_tdata[20], want.full));
        if (m_axis_tdata[21] !== want.cold)
            flag_error($sformatf("too_cold got %b want %b", m_axis_tdata[21], want.cold));
        if (m_axis_tdata[22] !== want.hot)
            flag_error($sformatf("too_hot got %b want %b", m_axis_tdata[22], want.hot));
    endtask

    // sender: gap per item counts down after the item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_reports.push_back(predict_report(offered));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait != 0) begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_readings.size() != 0) begin
                    offered = pending_readings.pop_front();
                    s_axis_tdata  <= {offered.temperature, offered.sensor_id};
                    s_axis_tvalid <= 1'b1;
                    src_wait      <= draw_gap(src_idle_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : drain
        int gap;
        gap = sink_wait;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_report();
                gap = draw_gap(sink_idle_on);
            end else if (gap != 0) begin
                gap = gap - 1;
            end
            sink_wait     <= gap;
            m_axis_tready <= (gap == 0) && !hold_on;
        end
    end

    // long receiver hold-offs so the pipeline backs up into the input
    initial begin : sink_hold
        wait (n_accepted >= 90);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_on <= 1'b0;
        wait (n_accepted >= 420);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_reading(input logic [ID_W-1:0] id,
                                 input logic signed [TEMP_W-1:0] temp);
        t_reading rd;
        rd.sensor_id   = id;
        rd.temperature = temp;
        pending_readings.push_back(rd);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_readings.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [TEMP_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_MIN_TEMP)
            thr_min = val;
        else if (idx == CFG_MAX_TEMP)
            thr_max = val;
    endtask

    task automatic run_phase(input logic signed [TEMP_W-1:0] lo,
                             input logic signed [TEMP_W-1:0] hi,
                             input bit src_idle, input bit sink_idle, input int count);
        int                       base;
        int                       r;
        logic [ID_W-1:0]          id;
        logic signed [TEMP_W-1:0] temp;
        write_reg(CFG_MIN_TEMP, lo);
        write_reg(CFG_MAX_TEMP, hi);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        // readings cluster around one threshold so averages land on both sides of it
        base = ($urandom_range(0, 1) ? int'(thr_min) : int'(thr_max))
               + int'($urandom_range(0, 512)) - 256;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 80)
                id = SENSOR_IDS[$urandom_range(0, CHANNELS - 1)];
            else
                id = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 60)
                temp = clamp16(base + int'($urandom_range(0, 128)) - 64);
            else if (r < 85)
                temp = 16'($urandom_range(0, 65535));
            else
                temp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            queue_reading(id, temp);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        logic signed [TEMP_W-1:0] a;
        logic signed [TEMP_W-1:0] b;
        foreach (win_vals[c, k])
            win_vals[c][k] = '0;
        foreach (win_sum[c]) begin
            win_sum[c]  = 0;
            win_slot[c] = 0;
            win_fill[c] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset thresholds
        sink_idle_on = 1'b1;
        queue_reading(16'd0, 16'sh7FFF);
        queue_reading(16'hFFFF, 16'sh8000);
        queue_reading(16'd16, 16'sh0000);
        repeat (WIN) queue_reading(SENSOR_IDS[0], 16'sh7FFF);   // fills, ends too hot
        repeat (WIN) queue_reading(SENSOR_IDS[1], 16'sh8000);   // fills, ends too cold
        queue_reading(SENSOR_IDS[2], -16'sd1);                 // partial window rounds down
        queue_reading(SENSOR_IDS[3], 16'sd7);
        queue_reading(SENSOR_IDS[4], -16'sd9);
        queue_reading(SENSOR_IDS[5], 16'sh7FFF);
        queue_reading(SENSOR_IDS[6], 16'sh8000);
        queue_reading(SENSOR_IDS[7], 16'sd1);
        wait_drained();

        run_phase(16'sh8000, 16'sh7FFF, 1'b1, 1'b1, PHASE_ITEMS);   // alarms never fire
        run_phase(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, PHASE_ITEMS);   // nearly always fire
        run_phase(16'sh0000, 16'sh0000, 1'b1, 1'b0, PHASE_ITEMS);
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        if (a > b)
            run_phase(b, a, 1'b0, 1'b1, PHASE_ITEMS);
        else
            run_phase(a, b, 1'b0, 1'b1, PHASE_ITEMS);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'b1, 1'b1, PHASE_ITEMS);
        run_phase(MIN_TEMP_RST, MAX_TEMP_RST, 1'b1, 1'b1, PHASE_ITEMS);

        repeat (16) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
